FILE: src/pbp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pbp_pkg;

    localparam int NUM_ROWS_DEF = 256;
    localparam int HIST_LEN_DEF = 30;

    localparam int PC_W   = 32;
    localparam int THR_W  = 7;
    localparam int BIAS_W = 16;
    localparam int WGT_W  = 8;
    // Wide enough for the bias plus 62 weights of magnitude 128, so the sum never wraps.
    localparam int SUM_W  = 18;

    localparam logic [THR_W-1:0] THR_RESET = 7'd60;

    localparam logic signed [BIAS_W-1:0] BIAS_MAX = 16'sh7FFF;
    localparam logic signed [BIAS_W-1:0] BIAS_MIN = 16'sh8000;

    typedef struct packed {
        logic            kind;
        logic [PC_W-1:0] pc;
        logic            outcome;
    } pbp_in_t;

    typedef struct packed {
        logic prediction;
        logic mispredicted;
        logic weights_updated;
    } pbp_out_t;

    typedef struct packed {
        logic load;
        logic add;
        logic sub;
    } acc_ctrl_t;

    // One training step of a history weight: it moves only while the new magnitude
    // stays below the threshold.
    function automatic logic signed [WGT_W-1:0] wgt_step(
        input logic signed [WGT_W-1:0] w,
        input logic                    agree,
        input logic [THR_W-1:0]        thr
    );
        logic signed [WGT_W:0] cand;
        logic        [WGT_W:0] mag;
        cand = agree ? ({w[WGT_W-1], w} + 9'sd1) : ({w[WGT_W-1], w} - 9'sd1);
        mag  = cand[WGT_W] ? (~cand + 9'd1) : cand;
        if (mag < {{(WGT_W+1-THR_W){1'b0}}, thr})
        begin
            return cand[WGT_W-1:0];
        end
        return w;
    endfunction

    function automatic logic signed [BIAS_W-1:0] bias_step(
        input logic signed [BIAS_W-1:0] b,
        input logic                     taken
    );
        if (taken)
        begin
            return (b == BIAS_MAX) ? b : b + 16'sd1;
        end
        return (b == BIAS_MIN) ? b : b - 16'sd1;
    endfunction

endpackage

`default_nettype wire

FILE: src/pbp_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module pbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: src/pbp_acc.sv
`timescale 1ns / 1ps
`default_nettype none

module pbp_acc (
    input  wire logic                             clk,
    input  wire pbp_pkg::acc_ctrl_t               ctrl,
    input  wire logic signed [pbp_pkg::SUM_W-1:0] operand,
    output logic signed [pbp_pkg::SUM_W-1:0]      y
);

    logic signed [pbp_pkg::SUM_W-1:0] y_reg;
    logic signed [pbp_pkg::SUM_W-1:0] y_next;
    logic signed [pbp_pkg::SUM_W-1:0] addend;

    // The single adder serves both signs of a history weight.
    always_comb
    begin
        addend = ctrl.sub ? -operand : operand;
        y_next = y_reg;
        if (ctrl.load)
        begin
            y_next = operand;
        end
        else if (ctrl.add || ctrl.sub)
        begin
            y_next = y_reg + addend;
        end
    end

    always_ff @(posedge clk)
    begin
        y_reg <= y_next;
    end

    assign y = y_reg;

endmodule

`default_nettype wire

FILE: src/perceptron_branch_predictor_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// A request passes through S_BASE, S_BIAS, the S_SUM walk and S_DECIDE before S_FINISH
// registers its response; training adds S_TFETCH and the S_TRAIN walk, and a row count that
// is not a power of two adds S_RECIP and S_MOD for the row selection. One adder walks the bias
// and each history weight, one a cycle; a new request beat is taken only after the last one's
// response is registered. Reset: after rst_n rises a clearing pass over the NUM_ROWS *
// HIST_LEN weights (7680) zeroes both tables, taking no request; the threshold resets to 60.

module perceptron_branch_predictor_unit #(
    parameter int NUM_ROWS = pbp_pkg::NUM_ROWS_DEF,
    parameter int HIST_LEN = pbp_pkg::HIST_LEN_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        req_valid,
    output logic                             req_ready,
    input  wire pbp_pkg::pbp_in_t            req,
    output logic                             rsp_valid,
    input  wire logic                        rsp_ready,
    output pbp_pkg::pbp_out_t                rsp,
    input  wire logic                        cfg_we,
    input  wire logic [pbp_pkg::THR_W-1:0]   cfg_data
);

    localparam int DEPTH    = NUM_ROWS * HIST_LEN;
    localparam int ROW_W    = $clog2(NUM_ROWS);
    localparam int ADDR_W   = $clog2(DEPTH);
    localparam int IDX_W    = $clog2(HIST_LEN + 1);
    localparam bit ROW_POW2 = ((1 << ROW_W) == NUM_ROWS);
    localparam int MOD_K    = pbp_pkg::PC_W + ROW_W;

    localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(DEPTH - 1);
    localparam logic [IDX_W-1:0]  IDX_LAST  = IDX_W'(HIST_LEN - 1);
    localparam logic [ADDR_W:0]   ROWS_EXT  = (ADDR_W+1)'(NUM_ROWS);
    localparam logic [ROW_W:0]    ROWS_MOD  = (ROW_W+1)'(NUM_ROWS);
    localparam logic [pbp_pkg::PC_W:0] MOD_RECIP =
        (pbp_pkg::PC_W+1)'((64'd1 << MOD_K) / NUM_ROWS);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_RECIP,
        S_MOD,
        S_BASE,
        S_BIAS,
        S_SUM,
        S_DECIDE,
        S_TFETCH,
        S_TRAIN,
        S_FINISH
    } state_t;

    state_t                              state_reg, state_next;
    logic [pbp_pkg::THR_W-1:0]           thr_reg, thr_next;
    logic [HIST_LEN-1:0]                 ghist_reg, ghist_next;
    logic [HIST_LEN-1:0]                 hsh_reg, hsh_next;
    logic [ADDR_W-1:0]                   clr_reg, clr_next;
    logic [ADDR_W-1:0]                   addr_reg, addr_next;
    logic [ADDR_W-1:0]                   base_reg, base_next;
    logic [ADDR_W-1:0]                   waddr_reg, waddr_next;
    logic [IDX_W-1:0]                    idx_reg, idx_next;
    logic [pbp_pkg::PC_W-1:0]            quot_reg, quot_next;
    logic [pbp_pkg::PC_W-1:0]            pcs_reg, pcs_next;
    logic [ROW_W-1:0]                    row_reg, row_next;
    logic                                kind_reg, kind_next;
    logic                                outc_reg, outc_next;
    logic signed [pbp_pkg::BIAS_W-1:0]   bias_reg, bias_next;
    pbp_pkg::pbp_out_t                   res_reg, res_next;
    pbp_pkg::pbp_out_t                   rsp_reg, rsp_next;
    logic                                rsp_valid_reg, rsp_valid_next;

    logic                                bias_we;
    logic [ROW_W-1:0]                    bias_waddr;
    logic [ROW_W-1:0]                    bias_raddr;
    logic [pbp_pkg::BIAS_W-1:0]          bias_wdata;
    logic [pbp_pkg::BIAS_W-1:0]          bias_rdata;
    logic                                hw_we;
    logic [ADDR_W-1:0]                   hw_waddr;
    logic [pbp_pkg::WGT_W-1:0]           hw_wdata;
    logic [pbp_pkg::WGT_W-1:0]           hw_rdata;

    pbp_pkg::acc_ctrl_t                  acc_ctrl;
    logic signed [pbp_pkg::SUM_W-1:0]    acc_op;
    logic signed [pbp_pkg::SUM_W-1:0]    acc_y;

    logic [2*pbp_pkg::PC_W:0]            recip_prod;
    logic [ROW_W:0]                      rem_low;
    logic [pbp_pkg::SUM_W-1:0]           y_mag;
    logic                                pred;
    logic                                miss;
    logic                                train;

    pbp_ram #(
        .WIDTH (pbp_pkg::BIAS_W),
        .DEPTH (NUM_ROWS)
    ) u_bias_ram (
        .clk   (clk),
        .we    (bias_we),
        .waddr (bias_waddr),
        .wdata (bias_wdata),
        .raddr (bias_raddr),
        .rdata (bias_rdata)
    );

    pbp_ram #(
        .WIDTH (pbp_pkg::WGT_W),
        .DEPTH (DEPTH)
    ) u_hw_ram (
        .clk   (clk),
        .we    (hw_we),
        .waddr (hw_waddr),
        .wdata (hw_wdata),
        .raddr (addr_reg),
        .rdata (hw_rdata)
    );

    pbp_acc u_acc (
        .clk     (clk),
        .ctrl    (acc_ctrl),
        .operand (acc_op),
        .y       (acc_y)
    );

    always_comb
    begin
        recip_prod = {{(pbp_pkg::PC_W+1){1'b0}}, pcs_reg} *
                     {{pbp_pkg::PC_W{1'b0}}, MOD_RECIP};
        rem_low    = pcs_reg[ROW_W:0] - (ROW_W+1)'(quot_reg[ROW_W:0] * ROWS_MOD);
        y_mag      = acc_y[pbp_pkg::SUM_W-1] ? -acc_y : acc_y;
        pred       = ~acc_y[pbp_pkg::SUM_W-1];
        miss       = kind_reg & (pred != outc_reg);
        train      = kind_reg & (miss | (y_mag <= pbp_pkg::SUM_W'(thr_reg)));
    end

    always_comb
    begin
        state_next     = state_reg;
        thr_next       = cfg_we ? cfg_data : thr_reg;
        ghist_next     = ghist_reg;
        hsh_next       = hsh_reg;
        clr_next       = clr_reg;
        addr_next      = addr_reg;
        base_next      = base_reg;
        waddr_next     = waddr_reg;
        idx_next       = idx_reg;
        quot_next      = quot_reg;
        pcs_next       = pcs_reg;
        row_next       = row_reg;
        kind_next      = kind_reg;
        outc_next      = outc_reg;
        bias_next      = bias_reg;
        res_next       = res_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg & ~rsp_ready;

        bias_we    = 1'b0;
        bias_waddr = row_reg;
        bias_wdata = pbp_pkg::bias_step(bias_reg, outc_reg);
        bias_raddr = row_reg;
        hw_we      = 1'b0;
        hw_waddr   = waddr_reg;
        hw_wdata   = pbp_pkg::wgt_step(hw_rdata, hsh_reg[0] == outc_reg, thr_reg);
        acc_ctrl   = '0;
        acc_op     = hw_rdata[pbp_pkg::WGT_W-1] ?
                     {{(pbp_pkg::SUM_W-pbp_pkg::WGT_W){1'b1}}, hw_rdata} :
                     {{(pbp_pkg::SUM_W-pbp_pkg::WGT_W){1'b0}}, hw_rdata};
        req_ready  = (state_reg == S_IDLE);

        unique case (state_reg)
            S_CLEAR:
            begin
                hw_we      = 1'b1;
                hw_waddr   = clr_reg;
                hw_wdata   = '0;
                bias_we    = ({1'b0, clr_reg} < ROWS_EXT);
                bias_waddr = clr_reg[ROW_W-1:0];
                bias_wdata = '0;
                clr_next   = clr_reg + 1'b1;
                if (clr_reg == ADDR_LAST)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    kind_next = req.kind;
                    outc_next = req.outcome;
                    pcs_next  = req.pc;
                    if (ROW_POW2)
                    begin
                        row_next   = req.pc[ROW_W-1:0];
                        state_next = S_BASE;
                    end
                    else
                    begin
                        state_next = S_RECIP;
                    end
                end
            end
            S_RECIP:
            begin
                // The reciprocal estimate of the quotient is at most one short.
                quot_next  = pbp_pkg::PC_W'(recip_prod >> MOD_K);
                state_next = S_MOD;
            end
            S_MOD:
            begin
                row_next   = (rem_low >= ROWS_MOD) ? ROW_W'(rem_low - ROWS_MOD)
                                                   : rem_low[ROW_W-1:0];
                state_next = S_BASE;
            end
            S_BASE:
            begin
                base_next  = ADDR_W'(row_reg * HIST_LEN);
                addr_next  = ADDR_W'(row_reg * HIST_LEN);
                state_next = S_BIAS;
            end
            S_BIAS:
            begin
                acc_ctrl.load = 1'b1;
                acc_op        = {{(pbp_pkg::SUM_W-pbp_pkg::BIAS_W){bias_rdata[pbp_pkg::BIAS_W-1]}},
                                 bias_rdata};
                bias_next     = bias_rdata;
                hsh_next      = ghist_reg;
                addr_next     = addr_reg + 1'b1;
                idx_next      = '0;
                state_next    = S_SUM;
            end
            S_SUM:
            begin
                acc_ctrl.add = hsh_reg[0];
                acc_ctrl.sub = ~hsh_reg[0];
                hsh_next     = hsh_reg >> 1;
                if (idx_reg == IDX_LAST)
                begin
                    state_next = S_DECIDE;
                end
                else
                begin
                    addr_next = addr_reg + 1'b1;
                    idx_next  = idx_reg + 1'b1;
                end
            end
            S_DECIDE:
            begin
                res_next.prediction      = pred;
                res_next.mispredicted    = miss;
                res_next.weights_updated = train;
                if (train)
                begin
                    bias_we    = 1'b1;
                    addr_next  = base_reg;
                    hsh_next   = ghist_reg;
                    state_next = S_TFETCH;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_TFETCH:
            begin
                waddr_next = addr_reg;
                addr_next  = addr_reg + 1'b1;
                idx_next   = '0;
                state_next = S_TRAIN;
            end
            S_TRAIN:
            begin
                hw_we    = 1'b1;
                hsh_next = hsh_reg >> 1;
                if (idx_reg == IDX_LAST)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    waddr_next = addr_reg;
                    addr_next  = addr_reg + 1'b1;
                    idx_next   = idx_reg + 1'b1;
                end
            end
            S_FINISH:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_next       = res_reg;
                    rsp_valid_next = 1'b1;
                    if (kind_reg)
                    begin
                        ghist_next = (ghist_reg << 1) | HIST_LEN'(outc_reg);
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            thr_reg       <= pbp_pkg::THR_RESET;
            ghist_reg     <= '0;
            clr_reg       <= '0;
            rsp_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            thr_reg       <= thr_next;
            ghist_reg     <= ghist_next;
            clr_reg       <= clr_next;
            rsp_reg       <= rsp_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hsh_reg   <= hsh_next;
        addr_reg  <= addr_next;
        base_reg  <= base_next;
        waddr_reg <= waddr_next;
        idx_reg   <= idx_next;
        quot_reg  <= quot_next;
        pcs_reg   <= pcs_next;
        row_reg   <= row_next;
        kind_reg  <= kind_next;
        outc_reg  <= outc_next;
        bias_reg  <= bias_next;
        res_reg   <= res_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

`default_nettype wire

FILE: src/pbp_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module pbp_checker (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              req_valid,
    input  wire logic              req_ready,
    input  wire logic              rsp_valid,
    input  wire logic              rsp_ready,
    input  wire pbp_pkg::pbp_out_t rsp
);

    // Beats taken in but not yet delivered.
    logic [1:0] pending_reg, pending_next;

    always_comb
    begin
        pending_next = pending_reg + 2'((req_valid && req_ready) ? 1 : 0)
                                   - 2'((rsp_valid && rsp_ready) ? 1 : 0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("response beat changed while stalled");

    a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while a request is in progress");

    a_miss_trains: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.mispredicted |-> rsp.weights_updated)
        else $error("mispredict reported without a weight update");

    a_no_spurious_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> pending_reg != 2'd0)
        else $error("response beat without an outstanding request");

    a_pending_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg != 2'd3)
        else $error("more than two requests outstanding");

endmodule

bind perceptron_branch_predictor_unit pbp_checker u_pbp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);

`default_nettype wire

FILE: tb/perceptron_branch_predictor_unit_tb.sv
`timescale 1ns / 1ps

module perceptron_branch_predictor_unit_tb;

    localparam int ROWS = pbp_pkg::NUM_ROWS_DEF;
    localparam int HLEN = pbp_pkg::HIST_LEN_DEF;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int SETTLE_CYCLES = 2 * HLEN + 40;
    localparam int PHASE_COUNT = 6;
    localparam int PHASE_ITEMS = 315;
    localparam int NUM_DIRECTED = 14;

    localparam logic KIND_PREDICT = 1'b0;
    localparam logic KIND_TRAIN = 1'b1;

    localparam logic [pbp_pkg::THR_W-1:0] PHASE_THR [PHASE_COUNT] =
        '{7'd127, 7'd2, 7'd0, 7'd90, 7'd1, 7'd60};
    localparam logic [7:0] HOT_ROWS [4] = '{8'h00, 8'h05, 8'h80, 8'hFF};

    typedef struct packed {
        pbp_pkg::pbp_in_t  item;
        logic              typed;
        pbp_pkg::pbp_out_t res;
    } directed_row_t;

    localparam directed_row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
        '{'{KIND_PREDICT, 32'h0000_0000, 1'b0}, 1'b1, '{1'b1, 1'b0, 1'b0}},
        '{'{KIND_PREDICT, 32'hFFFF_FFFF, 1'b1}, 1'b1, '{1'b1, 1'b0, 1'b0}},
        '{'{KIND_TRAIN,   32'h0000_0000, 1'b1}, 1'b1, '{1'b1, 1'b0, 1'b1}},
        '{'{KIND_TRAIN,   32'hFFFF_FFFF, 1'b0}, 1'b1, '{1'b1, 1'b1, 1'b1}},
        '{'{KIND_TRAIN,   32'h0000_0000, 1'b0}, 1'b0, '0},
        '{'{KIND_PREDICT, 32'h0000_0100, 1'b1}, 1'b0, '0},
        '{'{KIND_TRAIN,   32'hAAAA_AA55, 1'b1}, 1'b0, '0},
        '{'{KIND_TRAIN,   32'h5555_55AA, 1'b0}, 1'b0, '0},
        '{'{KIND_PREDICT, 32'h8000_0000, 1'b0}, 1'b0, '0},
        '{'{KIND_TRAIN,   32'h7FFF_FF00, 1'b0}, 1'b0, '0},
        '{'{KIND_TRAIN,   32'h0000_0000, 1'b0}, 1'b0, '0},
        '{'{KIND_TRAIN,   32'hFFFF_FF00, 1'b1}, 1'b0, '0},
        '{'{KIND_TRAIN,   32'h1234_56FF, 1'b1}, 1'b0, '0},
        '{'{KIND_PREDICT, 32'hFFFF_FFFF, 1'b0}, 1'b0, '0}
    };

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    pbp_pkg::pbp_in_t req = '0;
    logic rsp_ready = 1'b0;
    logic cfg_we = 1'b0;
    logic [pbp_pkg::THR_W-1:0] cfg_data = '0;
    logic req_ready;
    logic rsp_valid;
    pbp_pkg::pbp_out_t rsp;

    logic signed [pbp_pkg::BIAS_W-1:0] bias_model [ROWS];
    logic signed [pbp_pkg::WGT_W-1:0] weight_model [ROWS][HLEN];
    logic [HLEN-1:0] history_model;
    logic [pbp_pkg::THR_W-1:0] threshold_model;

    pbp_pkg::pbp_out_t pending_predictions [$];
    int errors = 0;
    int cycle_count = 0;
    int burst_left = 0;
    int ready_run = 0;
    int stall_run = 0;

    perceptron_branch_predictor_unit #(
        .NUM_ROWS(ROWS),
        .HIST_LEN(HLEN)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .req(req),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .rsp(rsp),
        .cfg_we(cfg_we),
        .cfg_data(cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // The receiver alternates runs of acceptance with stalls of varied length.
    always @(negedge clk)
    begin
        if (ready_run > 0)
        begin
            rsp_ready = 1'b1;
            ready_run--;
        end
        else if (stall_run > 0)
        begin
            rsp_ready = 1'b0;
            stall_run--;
        end
        else
        begin
            rsp_ready = 1'b1;
            ready_run = $urandom_range(0, 80);
            stall_run = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 40)
                                                    : $urandom_range(0, 3);
        end
    end

    always @(posedge clk)
    begin
        pbp_pkg::pbp_out_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (pending_predictions.size() == 0)
            begin
                $error("response beat with no request outstanding");
                errors++;
            end
            else
            begin
                want = pending_predictions.pop_front();
                if (rsp.prediction !== want.prediction)
                begin
                    $error("prediction: expected %0b, got %0b",
                           want.prediction, rsp.prediction);
                    errors++;
                end
                if (rsp.mispredicted !== want.mispredicted)
                begin
                    $error("mispredicted: expected %0b, got %0b",
                           want.mispredicted, rsp.mispredicted);
                    errors++;
                end
                if (rsp.weights_updated !== want.weights_updated)
                begin
                    $error("weights_updated: expected %0b, got %0b",
                           want.weights_updated, rsp.weights_updated);
                    errors++;
                end
            end
        end
    end

    task automatic perceptron_update(input pbp_pkg::pbp_in_t b, output pbp_pkg::pbp_out_t res);
        int row;
        int y;
        int thr;
        int bias;
        int w;
        row = int'(b.pc % ROWS);
        thr = int'(threshold_model);
        y = int'(bias_model[row]);
        for (int i = 0; i < HLEN; i++)
        begin
            y += history_model[i] ? int'(weight_model[row][i]) : -int'(weight_model[row][i]);
        end
        res = '0;
        res.prediction = (y >= 0);
        if (b.kind == KIND_TRAIN)
        begin
            res.mispredicted = (res.prediction != b.outcome);
            if (res.mispredicted || ((y < 0) ? -y : y) <= thr)
            begin
                res.weights_updated = 1'b1;
                bias = int'(bias_model[row]);
                if (b.outcome)
                begin
                    if (bias < 32767)
                    begin
                        bias++;
                    end
                end
                else if (bias > -32768)
                begin
                    bias--;
                end
                bias_model[row] = bias[pbp_pkg::BIAS_W-1:0];
                for (int i = 0; i < HLEN; i++)
                begin
                    w = int'(weight_model[row][i]);
                    if (history_model[i] == b.outcome)
                    begin
                        if (((w + 1 < 0) ? -(w + 1) : (w + 1)) < thr)
                        begin
                            w++;
                        end
                    end
                    else if (((w - 1 < 0) ? -(w - 1) : (w - 1)) < thr)
                    begin
                        w--;
                    end
                    weight_model[row][i] = w[pbp_pkg::WGT_W-1:0];
                end
            end
            history_model = {history_model[HLEN-2:0], b.outcome};
        end
    endtask

    // Most branches hit a few hot rows with outcomes that follow the history,
    // so the weights climb towards the threshold; the rest are noise.
    function automatic pbp_pkg::pbp_in_t random_branch();
        pbp_pkg::pbp_in_t b;
        logic [7:0] row;
        b.pc = $urandom();
        b.kind = ($urandom_range(0, 99) < 80) ? KIND_TRAIN : KIND_PREDICT;
        b.outcome = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 99) < 75)
        begin
            row = HOT_ROWS[$urandom_range(0, 3)];
            b.pc[7:0] = row;
            b.outcome = history_model[row[2:0]] ^ row[7];
            if ($urandom_range(0, 9) == 0)
            begin
                b.outcome = ~b.outcome;
            end
        end
        return b;
    endfunction

    task automatic send_branch(input pbp_pkg::pbp_in_t b, input logic typed,
                               input pbp_pkg::pbp_out_t typed_res);
        pbp_pkg::pbp_out_t res;
        @(negedge clk);
        if (burst_left == 0)
        begin
            req_valid = 1'b0;
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 20);
            repeat ($urandom_range(1, 12)) @(negedge clk);
        end
        burst_left--;
        req = b;
        req_valid = 1'b1;
        do @(posedge clk); while (!req_ready);
        perceptron_update(b, res);
        pending_predictions.push_back(typed ? typed_res : res);
    endtask

    task automatic drain_responses();
        @(negedge clk);
        req_valid = 1'b0;
        while (pending_predictions.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic set_threshold(input logic [pbp_pkg::THR_W-1:0] thr);
        drain_responses();
        cfg_data = thr;
        cfg_we = 1'b1;
        @(negedge clk);
        cfg_we = 1'b0;
        threshold_model = thr;
    endtask

    initial
    begin
        for (int r = 0; r < ROWS; r++)
        begin
            bias_model[r] = '0;
            for (int i = 0; i < HLEN; i++)
            begin
                weight_model[r][i] = '0;
            end
        end
        history_model = '0;
        threshold_model = pbp_pkg::THR_RESET;

        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        for (int n = 0; n < NUM_DIRECTED; n++)
        begin
            send_branch(DIRECTED_ROWS[n].item, DIRECTED_ROWS[n].typed, DIRECTED_ROWS[n].res);
        end

        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            set_threshold(PHASE_THR[p]);
            repeat (PHASE_ITEMS) send_branch(random_branch(), 1'b0, '0);
        end

        drain_responses();
        if (errors == 0 && pending_predictions.size() == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

FILE: files.f
src/pbp_pkg.sv
src/pbp_ram.sv
src/pbp_acc.sv
src/perceptron_branch_predictor_unit.sv
src/pbp_checker.sv
tb/perceptron_branch_predictor_unit_tb.sv
